// File: rtl/shs_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
// Used by shs_ctrl, shs_datapath and sha256_hash_stream; no dependencies.
package shs_pkg;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  word_bytes;
      logic        last_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INSERT_REQ,
      OP_INSERT_PEND,
      OP_PAD,
      OP_PAD2,
      OP_LOAD,
      OP_ROUND,
      OP_UPDATE,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic pend_left;
      logic last;
      logic pad_ovf;
      logic last_round;
      logic out_busy;
   } dp_status_type;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [2:0] WORD_BYTES = 3'd4;
   localparam logic [5:0] PAD_LIMIT  = 6'd55;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

// File: rtl/shs_ctrl.sv
// Sequencer for the SHA-256 stream hasher: byte insertion, padding,
// compression rounds and digest hand-off. Depends on shs_pkg.
module shs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output shs_pkg::dp_cmd_type   cmd,
   input  shs_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_PAD,
      S_PAD2,
      S_LOAD,
      S_ROUND,
      S_UPDATE,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_SPILL,
      PH_FINAL
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cmd.op   = shs_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = shs_pkg::OP_INSERT_REQ;
               if (status.full) begin
                  phase_in = PH_DATA;
                  state_in = S_LOAD;
               end else if (status.last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_INSERT: begin
            cmd.op = shs_pkg::OP_INSERT_PEND;
            if (status.full) begin
               phase_in = PH_DATA;
               state_in = S_LOAD;
            end else if (status.last) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PAD: begin
            cmd.op   = shs_pkg::OP_PAD;
            phase_in = status.pad_ovf ? PH_SPILL : PH_FINAL;
            state_in = S_LOAD;
         end
         S_PAD2: begin
            cmd.op   = shs_pkg::OP_PAD2;
            phase_in = PH_FINAL;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            cmd.op   = shs_pkg::OP_LOAD;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            cmd.op = shs_pkg::OP_ROUND;
            if (status.last_round) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.op = shs_pkg::OP_UPDATE;
            unique case (phase_ff)
               PH_SPILL: state_in = S_PAD2;
               PH_FINAL: state_in = S_EMIT;
               default: begin
                  if (status.pend_left) begin
                     state_in = S_INSERT;
                  end else if (status.last) begin
                     state_in = S_PAD;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            endcase
         end
         S_EMIT: begin
            if (!status.out_busy) begin
               cmd.op   = shs_pkg::OP_EMIT;
               phase_in = PH_DATA;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_DATA;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: rtl/shs_datapath.sv
// Datapath of the SHA-256 stream hasher: block buffer, schedule window,
// round unit, chaining value and digest output buffer. Depends on shs_pkg.
module shs_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  shs_pkg::req_payload_type req_payload,
   input  shs_pkg::dp_cmd_type      cmd,
   output shs_pkg::dp_status_type   status,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output shs_pkg::rsp_payload_type rsp_payload
);

   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] work_ff [8];
   logic [31:0] work_in [8];
   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];
   logic [31:0] dig_ff [8];
   logic [31:0] dig_in [8];
   logic [5:0]  fill_ff, fill_in;
   logic [31:0] len_ff, len_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] pend_word_ff, pend_word_in;
   logic [2:0]  pend_cnt_ff, pend_cnt_in;
   logic        last_ff, last_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        out_busy_ff, out_busy_in;

   logic        from_req;
   logic [31:0] src_word;
   logic [2:0]  src_cnt;
   logic [6:0]  room;
   logic [2:0]  take;
   logic [6:0]  fill_sum;
   logic        pad_ovf;
   logic [31:0] ch, maj, t1, t2, sched_new;

   assign from_req = (cmd.op == shs_pkg::OP_INSERT_REQ);
   assign src_word = from_req ? req_payload.message_word : pend_word_ff;
   assign src_cnt  = from_req ? ((req_payload.word_bytes > shs_pkg::WORD_BYTES) ?
                                 shs_pkg::WORD_BYTES : req_payload.word_bytes)
                              : pend_cnt_ff;
   assign room     = 7'd64 - {1'b0, fill_ff};
   assign take     = ({4'b0, src_cnt} < room) ? src_cnt : room[2:0];
   assign fill_sum = {1'b0, fill_ff} + {4'b0, take};
   assign pad_ovf  = (fill_ff > shs_pkg::PAD_LIMIT);

   assign ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
   assign maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
                (work_ff[1] & work_ff[2]);
   assign t1  = work_ff[7] + shs_pkg::bsig1(work_ff[4]) + ch +
                shs_pkg::ROUND_K[round_ff] + buf_ff[0];
   assign t2  = shs_pkg::bsig0(work_ff[0]) + maj;
   assign sched_new = shs_pkg::ssig1(buf_ff[14]) + buf_ff[9] +
                      shs_pkg::ssig0(buf_ff[1]) + buf_ff[0];

   assign status.full       = fill_sum[6];
   assign status.pend_left  = (pend_cnt_ff != 3'd0);
   assign status.last       = from_req ? req_payload.last_word : last_ff;
   assign status.pad_ovf    = pad_ovf;
   assign status.last_round = (round_ff == 6'd63);
   assign status.out_busy   = out_busy_ff;

   always_comb begin
      logic [5:0] pos;
      pos          = '0;
      chain_in     = chain_ff;
      work_in      = work_ff;
      buf_in       = buf_ff;
      dig_in       = dig_ff;
      fill_in      = fill_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      pend_word_in = pend_word_ff;
      pend_cnt_in  = pend_cnt_ff;
      last_in      = last_ff;
      out_idx_in   = out_idx_ff;
      out_busy_in  = out_busy_ff;

      if (out_busy_ff && !rsp_stall) begin
         out_idx_in = out_idx_ff + 3'd1;
         if (out_idx_ff == 3'd7) begin
            out_busy_in = 1'b0;
         end
      end

      unique case (cmd.op)
         shs_pkg::OP_INSERT_REQ, shs_pkg::OP_INSERT_PEND: begin
            for (int j = 0; j < 4; j++) begin
               if (3'(j) < take) begin
                  pos = fill_ff + 6'(j);
                  buf_in[pos[5:2]][{~pos[1:0], 3'b000} +: 8] =
                     src_word[5'(31 - 8 * j) -: 8];
               end
            end
            pend_word_in = src_word << {take, 3'b000};
            pend_cnt_in  = src_cnt - take;
            fill_in      = fill_sum[5:0];
            len_in       = len_ff + {26'b0, take, 3'b000};
            if (from_req) begin
               last_in = req_payload.last_word;
            end
         end
         shs_pkg::OP_PAD: begin
            for (int b = 0; b < 64; b++) begin
               if (6'(b) == fill_ff) begin
                  buf_in[4'(b >> 2)][5'((3 - (b & 3)) * 8) +: 8] = shs_pkg::PAD_BYTE;
               end else if (6'(b) > fill_ff) begin
                  buf_in[4'(b >> 2)][5'((3 - (b & 3)) * 8) +: 8] = 8'h00;
               end
            end
            if (!pad_ovf) begin
               buf_in[14] = '0;
               buf_in[15] = len_ff;
            end
         end
         shs_pkg::OP_PAD2: begin
            for (int i = 0; i < 15; i++) begin
               buf_in[4'(i)] = '0;
            end
            buf_in[15] = len_ff;
         end
         shs_pkg::OP_LOAD: begin
            work_in  = chain_ff;
            round_in = '0;
         end
         shs_pkg::OP_ROUND: begin
            work_in[7] = work_ff[6];
            work_in[6] = work_ff[5];
            work_in[5] = work_ff[4];
            work_in[4] = work_ff[3] + t1;
            work_in[3] = work_ff[2];
            work_in[2] = work_ff[1];
            work_in[1] = work_ff[0];
            work_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               buf_in[4'(i)] = buf_ff[4'(i + 1)];
            end
            buf_in[15] = sched_new;
            round_in   = round_ff + 6'd1;
         end
         shs_pkg::OP_UPDATE: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[3'(i)] = chain_ff[3'(i)] + work_ff[3'(i)];
            end
         end
         shs_pkg::OP_EMIT: begin
            dig_in      = chain_ff;
            out_busy_in = 1'b1;
            out_idx_in  = '0;
            chain_in    = shs_pkg::INIT_HASH;
            fill_in     = '0;
            len_in      = '0;
            pend_cnt_in = '0;
            last_in     = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff    <= shs_pkg::INIT_HASH;
         fill_ff     <= '0;
         len_ff      <= '0;
         round_ff    <= '0;
         pend_cnt_ff <= '0;
         last_ff     <= 1'b0;
         out_idx_ff  <= '0;
         out_busy_ff <= 1'b0;
      end else begin
         chain_ff    <= chain_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         round_ff    <= round_in;
         pend_cnt_ff <= pend_cnt_in;
         last_ff     <= last_in;
         out_idx_ff  <= out_idx_in;
         out_busy_ff <= out_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      buf_ff       <= buf_in;
      dig_ff       <= dig_in;
      pend_word_ff <= pend_word_in;
   end

   assign rsp_valid                = out_busy_ff;
   assign rsp_payload.digest_word  = dig_ff[out_idx_ff];
   assign rsp_payload.digest_index = out_idx_ff;
   assign rsp_payload.digest_last  = (out_idx_ff == 3'd7);

   // leftover bytes after a block boundary never exceed three
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_cnt_ff <= 3'd3)
      else $error("pending byte count out of range");

   a_pend_block_start: assert property (@(posedge clock) disable iff (reset)
      cmd.op == shs_pkg::OP_INSERT_PEND |-> pend_cnt_ff != 3'd0 && fill_ff == 6'd0)
      else $error("leftover insert outside block start");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == shs_pkg::OP_EMIT |-> !out_busy_ff)
      else $error("digest overwritten while draining");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      $fell(out_busy_ff) |-> $past(out_idx_ff == 3'd7 && !rsp_stall))
      else $error("digest output ended early");

endmodule

// File: rtl/sha256_hash_stream.sv
// SHA-256 over a word stream: words are taken while the current 64-byte block
// has room. Each full block goes through the single round unit (load, 64
// rounds, chain update); bytes spilling past a block boundary add an insert
// step. A final word adds a pad step and one compression, or two compressions
// with a second pad step between them when more than 55 bytes are buffered;
// an emit step then moves the digest to the output buffer. The eight digest
// words leave one per transfer from that buffer while the next message
// streams in; a new digest waits only if the previous one is still draining.
// Depends on shs_pkg, shs_ctrl and shs_datapath.
module sha256_hash_stream (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  shs_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output shs_pkg::rsp_payload_type rsp_payload
);

   shs_pkg::dp_cmd_type    cmd;
   shs_pkg::dp_status_type status;

   shs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   shs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sim/testbench.sv
// Self-checking testbench for sha256_hash_stream: directed vectors, then random messages.
// Expected digests come from an in-file SHA-256 model, or for known rows from the table.
// DUT sees random idles and stalls. Depends on shs_pkg for the transfer payload types.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      shs_pkg::req_payload_type item;
      logic                     known;
      logic [255:0]             digest;
   } stim_row_type;

   localparam int unsigned DIRECTED_COUNT = 20;
   localparam int unsigned RANDOM_WORDS   = 200;
   localparam int unsigned IDLE_LIMIT     = 5000;
   localparam int unsigned HOLD_CYCLES    = 800;
   localparam int unsigned DRAIN_CYCLES   = 200;

   localparam logic [31:0] SHA_IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // known digests: empty message, "abc", and the 56-byte two-block vector
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{'{32'h00000000, 3'd0, 1'b1}, 1'b1,
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855},
      '{'{32'h61626300, 3'd3, 1'b1}, 1'b1,
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad},
      '{'{32'h61626364, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h62636465, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h63646566, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h64656667, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h65666768, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h66676869, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h6768696a, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h68696a6b, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h696a6b6c, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h6a6b6c6d, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h6b6c6d6e, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h6c6d6e6f, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h6d6e6f70, 3'd4, 1'b0}, 1'b0, 256'h0},
      '{'{32'h6e6f7071, 3'd4, 1'b1}, 1'b1,
        256'h248d6a61d20638b8e5c026930c3e6039a33ce45964ff2167f6ecedd419db06c1},
      '{'{32'hffffffff, 3'd7, 1'b0}, 1'b0, 256'h0},
      '{'{32'hdeadbeef, 3'd0, 1'b0}, 1'b0, 256'h0},
      '{'{32'ha5000000, 3'd1, 1'b0}, 1'b0, 256'h0},
      '{'{32'hffffffff, 3'd6, 1'b1}, 1'b0, 256'h0}
   };

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   shs_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   shs_pkg::rsp_payload_type rsp_payload;

   sha256_hash_stream u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // hash model state
   logic [31:0] hs_chain [8];
   logic [31:0] hs_block [16];
   int unsigned hs_fill;
   logic [31:0] hs_bits;

   shs_pkg::rsp_payload_type digest_expect_q [$];
   stim_row_type stim_q [$];

   int unsigned words_taken = 0;
   int unsigned digest_words_seen = 0;
   int unsigned digests_seen = 0;
   int unsigned messages_sent = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned fail_count = 0;
   int unsigned idle_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic void sha_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = hs_block[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = s1 + w[i-7] + s0 + w[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hs_chain[i];
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hs_chain[i] = hs_chain[i] + v[i];
   endfunction

   function automatic void put_byte(int unsigned pos, logic [7:0] b);
      hs_block[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = b;
   endfunction

   function automatic void hash_restart();
      for (int i = 0; i < 8; i++) hs_chain[i] = SHA_IV[i];
      hs_fill = 0;
      hs_bits = '0;
   endfunction

   // absorbs one word; returns 1 with the digest when the word closes a message
   function automatic bit sha_absorb(shs_pkg::req_payload_type it, output logic [255:0] dig);
      int unsigned n;
      dig = '0;
      n = (it.word_bytes > 3'd4) ? 4 : it.word_bytes;
      for (int unsigned i = 0; i < n; i++) begin
         put_byte(hs_fill, it.message_word[31 - 8 * i -: 8]);
         hs_bits = hs_bits + 32'd8;
         hs_fill++;
         if (hs_fill == 64) begin
            sha_compress();
            hs_fill = 0;
         end
      end
      if (!it.last_word) return 1'b0;
      put_byte(hs_fill, 8'h80);
      for (int unsigned i = hs_fill + 1; i < 64; i++) put_byte(i, 8'h00);
      if (hs_fill > 55) begin
         sha_compress();
         for (int i = 0; i < 16; i++) hs_block[i] = '0;
      end
      hs_block[14] = '0;
      hs_block[15] = hs_bits;
      sha_compress();
      for (int i = 0; i < 8; i++) dig[255 - 32 * i -: 32] = hs_chain[i];
      hash_restart();
      return 1'b1;
   endfunction

   function automatic void take_word(stim_row_type row);
      logic [255:0] dig;
      shs_pkg::rsp_payload_type want;
      if (sha_absorb(row.item, dig)) begin
         if (row.known) dig = row.digest;
         for (int k = 0; k < 8; k++) begin
            want.digest_word  = dig[255 - 32 * k -: 32];
            want.digest_index = 3'(k);
            want.digest_last  = (k == 7);
            digest_expect_q.push_back(want);
         end
         messages_sent++;
      end
   endfunction

   // sender: bursts and gaps, payload held while stalled
   initial begin
      stim_row_type row;
      int unsigned len, burst_left, gap_left;
      bit first;
      for (int i = 0; i < 16; i++) hs_block[i] = '0;
      hash_restart();
      foreach (DIRECTED_ROWS[i]) stim_q.push_back(DIRECTED_ROWS[i]);
      first = 1'b1;
      while (stim_q.size() < DIRECTED_COUNT + RANDOM_WORDS) begin
         // first message puts a block boundary inside its final word
         if (first) len = 16;
         else if ($urandom_range(0, 9) == 0) len = $urandom_range(20, 40);
         else len = $urandom_range(0, 16);
         row.known  = 1'b0;
         row.digest = '0;
         for (int unsigned k = 0; k <= len; k++) begin
            row.item.message_word = $urandom;
            row.item.last_word    = (k == len);
            if (first && k == 0) row.item.word_bytes = 3'd2;
            else if (first) row.item.word_bytes = 3'd4;
            else if (k == len || $urandom_range(0, 4) == 0)
               row.item.word_bytes = 3'($urandom_range(0, 7));
            else row.item.word_bytes = 3'd4;
            stim_q.push_back(row);
         end
         first = 1'b0;
      end

      burst_left = $urandom_range(1, 20);
      gap_left   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      while (words_taken < stim_q.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) begin
            take_word(stim_q[words_taken]);
            words_taken++;
         end
         if (!(req_valid && req_stall)) begin
            if (words_taken >= stim_q.size()) begin
               req_valid <= 1'b0;
            end else if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_payload <= stim_q[words_taken].item;
               if (burst_left <= 1) begin
                  burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                          : $urandom_range(1, 20);
                  gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                         : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end

      while (digest_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d words in %0d messages sent, %0d digests (%0d words) checked",
               words_taken, messages_sent, digests_seen, digest_words_seen);
      $display("input held off for %0d cycles, %0d mismatches",
               input_stall_cycles, fail_count);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   // receiver: changing stall pattern, plus one long hold-off
   int unsigned rx_mode = 0;
   int unsigned rx_mode_left = 0;
   int unsigned rx_hold_left = 0;
   bit rx_hold_done = 1'b0;
   int unsigned rx_phase = 0;

   always @(posedge clock) begin
      if (!rx_hold_done && words_taken >= DIRECTED_COUNT + 40) begin
         rx_hold_done = 1'b1;
         rx_hold_left = HOLD_CYCLES;
      end
      if (rx_hold_left > 0) begin
         rx_hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 120);
         end
         rx_mode_left--;
         rx_phase++;
         case (rx_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((rx_phase % 7) < 4);
         endcase
      end
   end

   // digest checker
   always @(posedge clock) begin
      shs_pkg::rsp_payload_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         digest_words_seen++;
         if (rsp_payload.digest_last) digests_seen++;
         if (digest_expect_q.size() == 0) begin
            $display("%0t: unexpected digest transfer, expected none, got %h",
                     $time, rsp_payload);
            fail_count++;
         end else begin
            want = digest_expect_q.pop_front();
            if (rsp_payload.digest_word !== want.digest_word) begin
               $display("%0t: digest_word mismatch, expected %h, got %h",
                        $time, want.digest_word, rsp_payload.digest_word);
               fail_count++;
            end
            if (rsp_payload.digest_index !== want.digest_index) begin
               $display("%0t: digest_index mismatch, expected %0d, got %0d",
                        $time, want.digest_index, rsp_payload.digest_index);
               fail_count++;
            end
            if (rsp_payload.digest_last !== want.digest_last) begin
               $display("%0t: digest_last mismatch, expected %b, got %b",
                        $time, want.digest_last, rsp_payload.digest_last);
               fail_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_stall_cycles++;
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("Verification failed");
         $finish;
      end
   end

endmodule

// File: filelist.f
rtl/shs_pkg.sv
rtl/shs_ctrl.sv
rtl/shs_datapath.sv
rtl/sha256_hash_stream.sv
sim/testbench.sv
